// ===== design/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// types, codes and helper functions for the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int CLT_MAX_ARGS = 16;
  localparam int CLT_MAX_RES  = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_PLAIN      = 3'd1,
    MODE_PLAIN_ESC  = 3'd2,
    MODE_QUOTED     = 3'd3,
    MODE_QUOTED_ESC = 3'd4,
    MODE_OVER       = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_UNTERM   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [4:0] arg_count;
    logic [1:0] status;
    logic       last;
  } res_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_N) r = CH_LF;
    else if (c == CH_R) r = CH_CR;
    else if (c == CH_T) r = CH_TAB;
    return r;
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [7:0] c,
                                  input logic [4:0] idx, input status_t st);
    res_t r;
    r.kind      = k;
    r.out_char  = (k == KIND_CHAR) ? c : 8'h00;
    r.arg_count = idx;
    r.status    = (k == KIND_DONE) ? st : ST_OK;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/clt_stream_if.sv =====
// ----------------------------------------------------------------------------
// clt_stream_if
// valid/ready channel carrying one request payload
// ----------------------------------------------------------------------------
interface clt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// splits a byte stream of command lines into argument characters, argument
// end markers and a line-done request with count and status
// ----------------------------------------------------------------------------
//  channel  | direction | payload                                   | handshake
//  in_chan  | sink      | ch                                        | valid/ready
//  out_chan | source    | kind, out_char, arg_count, status, last   | valid/ready
//
//  one input byte per cycle when each byte gives at most one result request and
//  out_chan is ready; a byte giving two or three results holds in_chan.ready
//  low while the three-deep result buffer drains, one per cycle while out_chan
//  is ready; bytes giving no result (separators between arguments, backslashes,
//  opening quotes) leave it empty; synchronous active-low reset empties the
//  buffer and returns the parser to between-arguments with count zero, status ok
//  out_chan stalls hold the buffer; input is taken once its last request leaves
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int MAX_ARGS = clt_pkg::CLT_MAX_ARGS
) (
  input  logic          clk,
  input  logic          rst_n,
  clt_stream_if.sink    in_chan,
  clt_stream_if.source  out_chan
);
  import clt_pkg::*;

  // parser state
  mode_t      mode_r, mode_nxt;
  logic [4:0] count_r, count_nxt;
  status_t    err_r, err_nxt;

  // result buffer, entry 0 is presented on out_chan
  res_t       res_r [CLT_MAX_RES];
  logic [1:0] pend_r;

  // results of the byte on in_chan
  res_t       res_v [CLT_MAX_RES];
  logic [1:0] nres_v;

  logic [7:0] ch;
  logic       sep;
  logic       in_fire, out_fire;
  logic [4:0] cur_idx;
  logic       at_limit;

  assign ch       = in_chan.data.ch;
  assign sep      = is_sep(ch);
  assign at_limit = (count_r >= 5'(MAX_ARGS));
  // index of the argument in progress; an argument always exists when used
  assign cur_idx  = count_r - 5'd1;

  assign out_chan.valid = (pend_r != 2'd0);
  assign out_chan.data  = res_r[0];
  // take a new byte when the buffer is empty or its last request leaves now
  assign in_chan.ready  = (pend_r == 2'd0) || ((pend_r == 2'd1) && out_chan.ready);

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  // next state of the parser
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (ch == CH_NUL) begin
      // line done: everything back to reset values
      mode_nxt  = MODE_BETWEEN;
      count_nxt = 5'd0;
      err_nxt   = ST_OK;
    end else begin
      case (mode_r)
        MODE_BETWEEN: begin
          if (!sep) begin
            if (at_limit) begin
              mode_nxt = MODE_OVER;
              err_nxt  = ST_TOO_MANY;
            end else begin
              count_nxt = count_r + 5'd1;
              if (ch == CH_QUOTE)    mode_nxt = MODE_QUOTED;
              else if (ch == CH_BSL) mode_nxt = MODE_PLAIN_ESC;
              else                   mode_nxt = MODE_PLAIN;
            end
          end
        end
        MODE_PLAIN: begin
          if (sep)               mode_nxt = MODE_BETWEEN;
          else if (ch == CH_BSL) mode_nxt = MODE_PLAIN_ESC;
        end
        MODE_PLAIN_ESC:  mode_nxt = MODE_PLAIN;
        MODE_QUOTED: begin
          if (ch == CH_QUOTE)    mode_nxt = MODE_BETWEEN;
          else if (ch == CH_BSL) mode_nxt = MODE_QUOTED_ESC;
        end
        MODE_QUOTED_ESC: mode_nxt = MODE_QUOTED;
        default:         mode_nxt = MODE_OVER;
      endcase
    end
  end

  // result requests caused by the byte
  always_comb begin
    status_t    st;
    logic [1:0] k;
    st = err_r;
    k  = 2'd0;
    for (int i = 0; i < CLT_MAX_RES; i++) begin
      res_v[i] = mk_res(KIND_CHAR, 8'h00, 5'd0, ST_OK);
    end
    if (ch == CH_NUL) begin
      case (mode_r)
        MODE_PLAIN: begin
          res_v[k] = mk_res(KIND_END, 8'h00, cur_idx, ST_OK);
          k = k + 2'd1;
        end
        MODE_PLAIN_ESC: begin
          // trailing backslash is kept as a character
          res_v[k] = mk_res(KIND_CHAR, CH_BSL, cur_idx, ST_OK);
          k = k + 2'd1;
          res_v[k] = mk_res(KIND_END, 8'h00, cur_idx, ST_OK);
          k = k + 2'd1;
        end
        MODE_QUOTED: st = ST_UNTERM;
        MODE_QUOTED_ESC: begin
          res_v[k] = mk_res(KIND_CHAR, CH_BSL, cur_idx, ST_OK);
          k = k + 2'd1;
          st = ST_UNTERM;
        end
        default: ;
      endcase
      res_v[k] = mk_res(KIND_DONE, 8'h00, count_r, st);
      k = k + 2'd1;
    end else begin
      case (mode_r)
        MODE_BETWEEN: begin
          // first character of a new plain argument; its index is the old count
          if (!sep && !at_limit && (ch != CH_QUOTE) && (ch != CH_BSL)) begin
            res_v[k] = mk_res(KIND_CHAR, ch, count_r, ST_OK);
            k = k + 2'd1;
          end
        end
        MODE_PLAIN: begin
          if (sep) begin
            res_v[k] = mk_res(KIND_END, 8'h00, cur_idx, ST_OK);
            k = k + 2'd1;
          end else if (ch != CH_BSL) begin
            res_v[k] = mk_res(KIND_CHAR, ch, cur_idx, ST_OK);
            k = k + 2'd1;
          end
        end
        MODE_PLAIN_ESC, MODE_QUOTED_ESC: begin
          res_v[k] = mk_res(KIND_CHAR, unescape(ch), cur_idx, ST_OK);
          k = k + 2'd1;
        end
        MODE_QUOTED: begin
          if (ch == CH_QUOTE) begin
            res_v[k] = mk_res(KIND_END, 8'h00, cur_idx, ST_OK);
            k = k + 2'd1;
          end else if (ch != CH_BSL) begin
            res_v[k] = mk_res(KIND_CHAR, ch, cur_idx, ST_OK);
            k = k + 2'd1;
          end
        end
        default: ;
      endcase
    end
    // flag the final request of this byte
    if (k != 2'd0) begin
      res_v[k - 2'd1].last = 1'b1;
    end
    nres_v = k;
  end

  // parser state and buffer fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      count_r <= 5'd0;
      err_r   <= ST_OK;
      pend_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        err_r   <= err_nxt;
        pend_r  <= nres_v;
      end else if (out_fire) begin
        pend_r  <= pend_r - 2'd1;
      end
    end
  end

  // buffer payload, loaded on a new byte, shifted as requests leave
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < CLT_MAX_RES; i++) begin
        res_r[i] <= res_v[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < CLT_MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

  // input is never taken while the buffer holds three requests
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 || !in_chan.ready)
    else $error("input taken while buffer holds three requests");

  // the count never passes the argument limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 5'(MAX_ARGS))
    else $error("argument count beyond limit");

  // a line-done request is always the final one of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.data.kind == KIND_DONE) |-> out_chan.data.last)
    else $error("line done without last");

  // line end returns the parser to its reset state
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (ch == CH_NUL) |=> (mode_r == MODE_BETWEEN) && (count_r == 5'd0)
                                  && (err_r == ST_OK))
    else $error("parser not cleared after line end");

  // too-many status only in the overflowed mode
  a_over_err: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == ST_TOO_MANY) |-> (mode_r == MODE_OVER))
    else $error("sticky error outside overflowed mode");

endmodule

// ===== verif/command_line_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb
// streams command lines into the tokenizer with random gaps on both channels,
// predicts every result request and compares it field by field on arrival
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;
  import clt_pkg::*;

  localparam int RANDOM_BYTES = 340;   // rough size of the random part
  localparam int IDLE_LIMIT   = 2000;  // cycles without any request moving
  localparam int DRAIN_CYCLES = 16;    // buffer depth plus a margin

  logic clk = 1'b0;
  logic rst_n;

  clt_stream_if #(.payload_t(in_t))  in_if ();
  clt_stream_if #(.payload_t(res_t)) out_if ();

  command_line_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes still to be offered, and results still owed by the block
  logic [7:0] line_bytes[$];
  res_t       token_q[$];
  int         total_bytes;
  int         sent;
  int         errors;

  // ---------------------------------------------------------------------------
  // tokenizer prediction, its own copy of the parser state
  // ---------------------------------------------------------------------------
  mode_t      tok_mode;
  logic [4:0] tok_count;
  status_t    tok_sticky;
  res_t       burst[$];

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // backslash pairs: n, r and t become control bytes, all else stays literal
  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    case (c)
      CH_N:    return CH_LF;
      CH_R:    return CH_CR;
      CH_T:    return CH_TAB;
      default: return c;
    endcase
  endfunction

  task automatic add_token(input kind_t k, input logic [7:0] c, input status_t st);
    res_t r;
    r.kind      = k;
    r.out_char  = (k == KIND_CHAR) ? c : 8'h00;
    // characters and end markers carry the index of the open argument,
    // line done carries the number of arguments started
    if (k == KIND_DONE)
      r.arg_count = tok_count;
    else
      r.arg_count = (tok_count != 5'd0) ? tok_count - 5'd1 : 5'd0;
    r.status    = (k == KIND_DONE) ? st : ST_OK;
    r.last      = 1'b0;
    burst.push_back(r);
  endtask

  task automatic clear_line();
    tok_mode   = MODE_BETWEEN;
    tok_count  = 5'd0;
    tok_sticky = ST_OK;
  endtask

  task automatic tokenize_byte(input logic [7:0] c);
    status_t st;
    burst.delete();
    if (c == CH_NUL) begin
      st = tok_sticky;
      case (tok_mode)
        MODE_PLAIN: begin
          add_token(KIND_END, 8'h00, ST_OK);
        end
        MODE_PLAIN_ESC: begin
          // dangling backslash is kept as a character
          add_token(KIND_CHAR, CH_BSL, ST_OK);
          add_token(KIND_END, 8'h00, ST_OK);
        end
        MODE_QUOTED: begin
          // open quote: no end marker, argument still counted
          st = ST_UNTERM;
        end
        MODE_QUOTED_ESC: begin
          add_token(KIND_CHAR, CH_BSL, ST_OK);
          st = ST_UNTERM;
        end
        default: ;
      endcase
      add_token(KIND_DONE, 8'h00, st);
      clear_line();
    end else begin
      case (tok_mode)
        MODE_BETWEEN: begin
          if (!blank(c)) begin
            if (tok_count >= CLT_MAX_ARGS) begin
              // one argument too many: the rest of the line is dropped
              tok_mode   = MODE_OVER;
              tok_sticky = ST_TOO_MANY;
            end else begin
              tok_count = tok_count + 5'd1;
              if (c == CH_QUOTE) begin
                tok_mode = MODE_QUOTED;
              end else if (c == CH_BSL) begin
                tok_mode = MODE_PLAIN_ESC;
              end else begin
                tok_mode = MODE_PLAIN;
                add_token(KIND_CHAR, c, ST_OK);
              end
            end
          end
        end
        MODE_PLAIN: begin
          if (blank(c)) begin
            add_token(KIND_END, 8'h00, ST_OK);
            tok_mode = MODE_BETWEEN;
          end else if (c == CH_BSL) begin
            tok_mode = MODE_PLAIN_ESC;
          end else begin
            // a quote inside a plain argument is just a character
            add_token(KIND_CHAR, c, ST_OK);
          end
        end
        MODE_PLAIN_ESC: begin
          add_token(KIND_CHAR, decode_escape(c), ST_OK);
          tok_mode = MODE_PLAIN;
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            // closing quote ends the argument even with no separator after it
            add_token(KIND_END, 8'h00, ST_OK);
            tok_mode = MODE_BETWEEN;
          end else if (c == CH_BSL) begin
            tok_mode = MODE_QUOTED_ESC;
          end else begin
            add_token(KIND_CHAR, c, ST_OK);
          end
        end
        MODE_QUOTED_ESC: begin
          add_token(KIND_CHAR, decode_escape(c), ST_OK);
          tok_mode = MODE_QUOTED;
        end
        default: tok_mode = MODE_OVER;
      endcase
    end
    if (burst.size() != 0) begin
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) token_q.push_back(burst[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: command line builders
  // ---------------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // mostly printable text, now and then any non-zero byte
  function automatic logic [7:0] pick_body();
    case ($urandom_range(3))
      0, 1:    return 8'h61 + 8'($urandom_range(25));
      2:       return 8'($urandom_range(1, 255));
      default: return 8'h30 + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] pick_escaped();
    case ($urandom_range(5))
      0:       return CH_N;
      1:       return CH_R;
      2:       return CH_T;
      3:       return CH_QUOTE;
      4:       return CH_BSL;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic add_argument(input bit quoted, input bit leave_open, input int max_len);
    int         len;
    logic [7:0] c;
    len = quoted ? $urandom_range(0, max_len) : $urandom_range(1, max_len);
    if (quoted) line_bytes.push_back(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(5) == 0) begin
        line_bytes.push_back(CH_BSL);
        line_bytes.push_back(pick_escaped());
      end else begin
        c = pick_body();
        // keep a plain argument from turning into a quoted one
        if (!quoted && i == 0 && c == CH_QUOTE) c = 8'h78;
        line_bytes.push_back(c);
      end
    end
    if (quoted && !leave_open) line_bytes.push_back(CH_QUOTE);
  endtask

  task automatic add_random_line();
    int sel;
    int nargs;
    int max_len;
    bit quoted;
    bit open_end;
    sel = $urandom_range(11);
    if (sel == 0) begin
      // noise: arbitrary bytes, whatever state they lead to
      repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      // sel 1: around the argument limit, exactly full or one to three too many; else zero to five
      nargs   = (sel == 1) ? $urandom_range(CLT_MAX_ARGS, CLT_MAX_ARGS + 3)
                           : $urandom_range(0, 5);
      max_len = (sel == 1) ? 2 : 6;
      if ($urandom_range(2) == 0) line_bytes.push_back(pick_blank());
      for (int a = 0; a < nargs; a++) begin
        quoted   = ($urandom_range(2) == 0);
        open_end = quoted && (a == nargs - 1) && ($urandom_range(5) == 0);
        add_argument(quoted, open_end, max_len);
        // a closed quote may be followed directly by the next argument
        if (a != nargs - 1 && !(quoted && $urandom_range(3) == 0))
          repeat ($urandom_range(1, 2)) line_bytes.push_back(pick_blank());
      end
      if ($urandom_range(9) == 0) line_bytes.push_back(CH_BSL);
      else if ($urandom_range(4) == 0) line_bytes.push_back(pick_blank());
    end
    line_bytes.push_back(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // idling: sender 9 / receiver 47, then swapped, then none at all
  // ---------------------------------------------------------------------------
  function automatic int send_idle_pct(input int n);
    if (n * 3 < total_bytes)     return 9;
    if (n * 3 < total_bytes * 2) return 47;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n * 3 < total_bytes)     return 47;
    if (n * 3 < total_bytes * 2) return 9;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: results are predicted when a byte is offered, which is always
  // before the block can answer it, so the expectation is queued in time
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct(sent)) begin
        tokenize_byte(line_bytes[0]);
        in_if.data  <= in_t'(line_bytes.pop_front());
        in_if.valid <= 1'b1;
        sent++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each result request checked on arrival
  // ---------------------------------------------------------------------------
  task automatic check_token(input res_t got);
    res_t want;
    logic bad;
    if (token_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind=%0d char=%02h arg=%0d status=%0d last=%0b",
                 got.kind, got.out_char, got.arg_count, got.status, got.last);
    end else begin
      want = token_q.pop_front();
      bad  = (got.kind != want.kind) || (got.out_char != want.out_char) ||
             (got.arg_count != want.arg_count) || (got.status != want.status) ||
             (got.last != want.last);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch: expected kind=%0d char=%02h arg=%0d status=%0d last=%0b",
                 want.kind, want.out_char, want.arg_count, want.status, want.last);
          $display(", got kind=%0d char=%02h arg=%0d status=%0d last=%0b",
                   got.kind, got.out_char, got.arg_count, got.status, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_token(out_if.data);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct(sent));
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: stimulus, reset, watchdog, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int  idle;
    bit  timed_out;
    int  directed;
    rst_n        = 1'b0;
    sent         = 0;
    errors       = 0;
    idle         = 0;
    timed_out    = 1'b0;
    clear_line();

    // directed lines
    line_bytes.push_back(CH_NUL);                          // empty line
    add_text(" a\tb\r\n");  line_bytes.push_back(CH_NUL);  // every separator
    add_text("\"x y\"z\\"); line_bytes.push_back(CH_NUL);  // quoted, glued, dangling bsl
    add_text("\\t\\q\"");   line_bytes.push_back(CH_NUL);  // escapes, quote mid-argument
    add_text("\"a\\");      line_bytes.push_back(CH_NUL);  // open quote, pending escape
    line_bytes.push_back(8'hFF);                           // byte extremes
    line_bytes.push_back(8'h01);
    line_bytes.push_back(CH_NUL);
    directed = line_bytes.size();

    // random lines, whole lines only
    while (line_bytes.size() < directed + RANDOM_BYTES) add_random_line();
    total_bytes = line_bytes.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // run until everything is offered, accepted and answered
    while (line_bytes.size() != 0 || in_if.valid || token_q.size() != 0) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end

    // stray results during the drain are caught by the monitor
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk);
    if (token_q.size() != 0) errors++;

    if (timed_out) begin
      $display("Testbench completed WITH ERRORS");
    end else if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
